/* rtl/core/rpi_pkg.sv */
// ----------------------------------------------------------------------------
// rpi_pkg
// Types and constants shared by the ray / plane intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rpi_pkg;

  localparam int COORD_W   = 16;
  localparam int VERTEX_W  = 3 * COORD_W;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int NORM_W    = PROD_W + 1;
  localparam int DOT_W     = NORM_W + EDGE_W + 2;
  localparam int DIST_W    = 32;
  localparam int DIST_FRAC = 16;
  localparam int DIV_STEPS = DIST_W;
  localparam int SCALE_W   = COORD_W + DIST_W + 1;
  localparam int STEP_W    = SCALE_W - DIST_FRAC;
  localparam int POINT_W   = STEP_W + 1;

  localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(66);
  localparam logic [DIST_W-1:0] DIST_MAX       = '1;

  typedef enum logic [1:0] {
    REG_VERTEX_A = 2'd0,
    REG_VERTEX_B = 2'd1,
    REG_VERTEX_C = 2'd2,
    REG_MIN_DIST = 2'd3
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } ray_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
    coord_t            point_x;
    coord_t            point_y;
    coord_t            point_z;
  } result_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } normal_t;

  typedef struct packed {
    ray_t                 ray;
    logic                 miss;
    logic                 sat;
    logic [DOT_W-1:0]     den;
    logic [DOT_W-1:0]     rem;
    logic [DIST_FRAC-1:0] nlow;
    logic [DIST_W-1:0]    quo;
  } div_t;

  function automatic coord_t coord_of(input logic [VERTEX_W-1:0] v, input int k);
    coord_of = v[k*COORD_W +: COORD_W];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rpi_normal.sv */
// ----------------------------------------------------------------------------
// rpi_normal
// Plane normal (B - A) x (C - A), rebuilt after a vertex write: products first, then the normal.
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_normal (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire logic [rpi_pkg::VERTEX_W-1:0]  vertex_a,
  input  wire logic [rpi_pkg::VERTEX_W-1:0]  vertex_b,
  input  wire logic [rpi_pkg::VERTEX_W-1:0]  vertex_c,
  output rpi_pkg::normal_t                   normal,
  output logic                               ready
);

  logic signed [rpi_pkg::EDGE_W-1:0] ab [3];
  logic signed [rpi_pkg::EDGE_W-1:0] ac [3];
  logic signed [rpi_pkg::PROD_W-1:0] prod [6];
  logic                              prod_ok;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab[k] = rpi_pkg::EDGE_W'(rpi_pkg::coord_of(vertex_b, k))
            - rpi_pkg::EDGE_W'(rpi_pkg::coord_of(vertex_a, k));
      ac[k] = rpi_pkg::EDGE_W'(rpi_pkg::coord_of(vertex_c, k))
            - rpi_pkg::EDGE_W'(rpi_pkg::coord_of(vertex_a, k));
    end
  end

  always_ff @(posedge clk) begin
    prod[0] <= ab[1] * ac[2];
    prod[1] <= ab[2] * ac[1];
    prod[2] <= ab[2] * ac[0];
    prod[3] <= ab[0] * ac[2];
    prod[4] <= ab[0] * ac[1];
    prod[5] <= ab[1] * ac[0];
    if (prod_ok && !ready) begin
      normal.x <= rpi_pkg::NORM_W'(prod[0]) - rpi_pkg::NORM_W'(prod[1]);
      normal.y <= rpi_pkg::NORM_W'(prod[2]) - rpi_pkg::NORM_W'(prod[3]);
      normal.z <= rpi_pkg::NORM_W'(prod[4]) - rpi_pkg::NORM_W'(prod[5]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prod_ok <= 1'b0;
      ready   <= 1'b0;
    end else if (!ready) begin
      if (!prod_ok) begin
        prod_ok <= 1'b1;
      end else begin
        ready <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rpi_front.sv */
// ----------------------------------------------------------------------------
// rpi_front
// Dot products with the normal, sign checks and divider set-up (four stages).
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  rpi_pkg::ray_t                      ray,
  input  wire logic [rpi_pkg::VERTEX_W-1:0]  vertex_a,
  input  rpi_pkg::normal_t                   normal,
  output logic                               out_valid,
  output rpi_pkg::div_t                      out
);

  localparam int PD_W = rpi_pkg::NORM_W + rpi_pkg::COORD_W;
  localparam int PN_W = rpi_pkg::NORM_W + rpi_pkg::EDGE_W;

  logic signed [rpi_pkg::NORM_W-1:0] n [3];
  rpi_pkg::coord_t                   org [3];

  logic                              a_valid;
  rpi_pkg::ray_t                     a_ray;
  logic signed [rpi_pkg::EDGE_W-1:0] a_rel [3];
  rpi_pkg::coord_t                   a_dir [3];

  logic                              b_valid;
  rpi_pkg::ray_t                     b_ray;
  logic signed [PD_W-1:0]            b_pd [3];
  logic signed [PN_W-1:0]            b_pn [3];

  logic                              c_valid;
  rpi_pkg::ray_t                     c_ray;
  logic signed [rpi_pkg::DOT_W-1:0]  c_den;
  logic signed [rpi_pkg::DOT_W-1:0]  c_num;

  logic [rpi_pkg::DOT_W-1:0]         nmag;
  logic [rpi_pkg::DOT_W-1:0]         dmag;
  logic                              miss;
  logic                              sat;

  assign n[0]   = normal.x;
  assign n[1]   = normal.y;
  assign n[2]   = normal.z;
  assign org[0] = ray.origin_x;
  assign org[1] = ray.origin_y;
  assign org[2] = ray.origin_z;
  assign a_dir[0] = a_ray.dir_x;
  assign a_dir[1] = a_ray.dir_y;
  assign a_dir[2] = a_ray.dir_z;

  always_comb begin
    nmag = c_num[rpi_pkg::DOT_W-1] ? rpi_pkg::DOT_W'(-c_num) : rpi_pkg::DOT_W'(c_num);
    dmag = c_den[rpi_pkg::DOT_W-1] ? rpi_pkg::DOT_W'(-c_den) : rpi_pkg::DOT_W'(c_den);
    miss = (c_den == '0)
        || ((c_num != '0) && (c_num[rpi_pkg::DOT_W-1] != c_den[rpi_pkg::DOT_W-1]));
    sat  = {{rpi_pkg::DIST_FRAC{1'b0}}, nmag} >= {dmag, {rpi_pkg::DIST_FRAC{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ray <= ray;
      for (int k = 0; k < 3; k++) begin
        a_rel[k] <= rpi_pkg::EDGE_W'(rpi_pkg::coord_of(vertex_a, k))
                  - rpi_pkg::EDGE_W'(org[k]);
      end
      b_ray <= a_ray;
      for (int k = 0; k < 3; k++) begin
        b_pd[k] <= n[k] * a_dir[k];
        b_pn[k] <= n[k] * a_rel[k];
      end
      c_ray <= b_ray;
      c_den <= rpi_pkg::DOT_W'(b_pd[0]) + rpi_pkg::DOT_W'(b_pd[1])
             + rpi_pkg::DOT_W'(b_pd[2]);
      c_num <= rpi_pkg::DOT_W'(b_pn[0]) + rpi_pkg::DOT_W'(b_pn[1])
             + rpi_pkg::DOT_W'(b_pn[2]);
      out.ray  <= c_ray;
      out.miss <= miss;
      out.sat  <= sat;
      out.den  <= dmag;
      out.rem  <= {{rpi_pkg::DIST_FRAC{1'b0}}, nmag[rpi_pkg::DOT_W-1:rpi_pkg::DIST_FRAC]};
      out.nlow <= nmag[rpi_pkg::DIST_FRAC-1:0];
      out.quo  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rpi_div.sv */
// ----------------------------------------------------------------------------
// rpi_div
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_div (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  rpi_pkg::div_t din,
  output logic          out_valid,
  output rpi_pkg::div_t dout
);

  rpi_pkg::div_t                    pipe [rpi_pkg::DIV_STEPS];
  logic                             valid [rpi_pkg::DIV_STEPS];

  for (genvar j = 0; j < rpi_pkg::DIV_STEPS; j++) begin : g_step
    localparam int IDX = rpi_pkg::DIV_STEPS - 1 - j;
    rpi_pkg::div_t              cur;
    rpi_pkg::div_t              nxt;
    logic                       cur_valid;
    logic [rpi_pkg::DOT_W:0]    r;
    logic [rpi_pkg::DOT_W:0]    diff;
    logic                       ge;

    if (j == 0) begin : g_first
      assign cur       = din;
      assign cur_valid = in_valid;
    end else begin : g_next
      assign cur       = pipe[j-1];
      assign cur_valid = valid[j-1];
    end

    if (IDX >= rpi_pkg::DIST_FRAC) begin : g_bit
      assign r = {cur.rem, cur.nlow[IDX-rpi_pkg::DIST_FRAC]};
    end else begin : g_zero
      assign r = {cur.rem, 1'b0};
    end

    always_comb begin
      diff = r - {1'b0, cur.den};
      ge   = r >= {1'b0, cur.den};
      nxt  = cur;
      nxt.rem      = ge ? diff[rpi_pkg::DOT_W-1:0] : r[rpi_pkg::DOT_W-1:0];
      nxt.quo[IDX] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[j] <= nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j] <= 1'b0;
      end else if (en) begin
        valid[j] <= cur_valid;
      end
    end
  end

  assign dout      = pipe[rpi_pkg::DIV_STEPS-1];
  assign out_valid = valid[rpi_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

/* rtl/core/rpi_back.sv */
// ----------------------------------------------------------------------------
// rpi_back
// Distance check, hit point scaling, rounding and saturation (two stages).
// ----------------------------------------------------------------------------
`default_nettype none

module rpi_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  rpi_pkg::div_t                    din,
  input  wire logic [rpi_pkg::DIST_W-1:0]  min_distance,
  output logic                             out_valid,
  output rpi_pkg::result_t                 result
);

  localparam logic signed [rpi_pkg::COORD_W-1:0] C_MAX = {1'b0, {(rpi_pkg::COORD_W-1){1'b1}}};
  localparam logic signed [rpi_pkg::COORD_W-1:0] C_MIN = {1'b1, {(rpi_pkg::COORD_W-1){1'b0}}};
  localparam logic signed [rpi_pkg::SCALE_W-1:0] HALF  =
    rpi_pkg::SCALE_W'(1) <<< (rpi_pkg::DIST_FRAC - 1);

  logic [rpi_pkg::DIST_W-1:0]         t;
  rpi_pkg::coord_t                    d_dir [3];
  rpi_pkg::coord_t                    d_org [3];

  logic                               e_valid;
  logic                               e_hit;
  logic [rpi_pkg::DIST_W-1:0]         e_t;
  rpi_pkg::coord_t                    e_org [3];
  logic signed [rpi_pkg::SCALE_W-1:0] e_prod [3];

  logic signed [rpi_pkg::SCALE_W-1:0] rnd [3];
  logic signed [rpi_pkg::POINT_W-1:0] p [3];
  rpi_pkg::coord_t                    ps [3];

  assign t = din.sat ? rpi_pkg::DIST_MAX : din.quo;
  assign d_dir[0] = din.ray.dir_x;
  assign d_dir[1] = din.ray.dir_y;
  assign d_dir[2] = din.ray.dir_z;
  assign d_org[0] = din.ray.origin_x;
  assign d_org[1] = din.ray.origin_y;
  assign d_org[2] = din.ray.origin_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = e_prod[k] + HALF;
      p[k]   = rpi_pkg::POINT_W'(e_org[k])
             + rpi_pkg::POINT_W'($signed(rnd[k][rpi_pkg::SCALE_W-1:rpi_pkg::DIST_FRAC]));
      if (p[k] > rpi_pkg::POINT_W'(C_MAX)) begin
        ps[k] = C_MAX;
      end else if (p[k] < rpi_pkg::POINT_W'(C_MIN)) begin
        ps[k] = C_MIN;
      end else begin
        ps[k] = p[k][rpi_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_hit <= !din.miss && (t >= min_distance);
      e_t   <= t;
      for (int k = 0; k < 3; k++) begin
        e_org[k]  <= d_org[k];
        e_prod[k] <= d_dir[k] * $signed({1'b0, t});
      end
      if (e_hit) begin
        result.hit      <= 1'b1;
        result.distance <= e_t;
        result.point_x  <= ps[0];
        result.point_y  <= ps[1];
        result.point_z  <= ps[2];
      end else begin
        result <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      e_valid   <= in_valid;
      out_valid <= e_valid;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ray_plane_intersect.sv */
// ----------------------------------------------------------------------------
// ray_plane_intersect
// Intersects a stream of rays with the plane of a configured triangle.
// ----------------------------------------------------------------------------
//   channel | signals                           | direction
//   ray     | ray_valid, ray_stall, ray         | in
//   res     | res_valid, res_stall, res         | out
//   cfg     | cfg_write, cfg_index, cfg_data    | in
//
// one ray per cycle while ray_stall is low; 4 dot product stages, 32 divider
// stages of one quotient bit each, 2 output stages
// after reset or a vertex write the normal is rebuilt, product registers first
// and then the normal registers, and ray_stall is high meanwhile
// a stalled result freezes the whole pipeline; nothing is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module ray_plane_intersect (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        ray_valid,
  output logic                             ray_stall,
  input  rpi_pkg::ray_t                    ray,
  output logic                             res_valid,
  input  wire logic                        res_stall,
  output rpi_pkg::result_t                 res,
  input  wire logic                        cfg_write,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [rpi_pkg::VERTEX_W-1:0] cfg_data
);

  logic [rpi_pkg::VERTEX_W-1:0] vertex_a;
  logic [rpi_pkg::VERTEX_W-1:0] vertex_b;
  logic [rpi_pkg::VERTEX_W-1:0] vertex_c;
  logic [rpi_pkg::DIST_W-1:0]   min_distance;
  rpi_pkg::cfg_reg_t            cfg_reg;
  logic                         vertex_write;

  rpi_pkg::normal_t             normal;
  logic                         normal_ready;
  logic                         en;
  logic                         transfer;

  logic                         front_valid;
  rpi_pkg::div_t                front_out;
  logic                         div_valid;
  rpi_pkg::div_t                div_out;

  assign cfg_reg      = rpi_pkg::cfg_reg_t'(cfg_index);
  assign vertex_write = cfg_write && (cfg_reg != rpi_pkg::REG_MIN_DIST);
  assign en           = !(res_valid && res_stall);
  assign ray_stall    = !en || !normal_ready;
  assign transfer     = ray_valid && !ray_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a     <= '0;
      vertex_b     <= '0;
      vertex_c     <= '0;
      min_distance <= rpi_pkg::MIN_DIST_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg)
        rpi_pkg::REG_VERTEX_A: vertex_a     <= cfg_data;
        rpi_pkg::REG_VERTEX_B: vertex_b     <= cfg_data;
        rpi_pkg::REG_VERTEX_C: vertex_c     <= cfg_data;
        rpi_pkg::REG_MIN_DIST: min_distance <= cfg_data[rpi_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  rpi_normal u_normal (
    .clk      (clk),
    .rst      (rst),
    .clear    (vertex_write),
    .vertex_a (vertex_a),
    .vertex_b (vertex_b),
    .vertex_c (vertex_c),
    .normal   (normal),
    .ready    (normal_ready)
  );

  rpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (transfer),
    .ray       (ray),
    .vertex_a  (vertex_a),
    .normal    (normal),
    .out_valid (front_valid),
    .out       (front_out)
  );

  rpi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .din       (front_out),
    .out_valid (div_valid),
    .dout      (div_out)
  );

  rpi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (div_valid),
    .din          (div_out),
    .min_distance (min_distance),
    .out_valid    (res_valid),
    .result       (res)
  );

  a_transfer_needs_normal: assert property (@(posedge clk) disable iff (rst)
    transfer |-> normal_ready)
    else $error("ray transfer with stale normal");

  a_vertex_write_clears: assert property (@(posedge clk) disable iff (rst)
    vertex_write |=> !normal_ready)
    else $error("normal not invalidated by vertex write");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.hit) |-> (res.distance == '0 && res.point_x == '0
      && res.point_y == '0 && res.point_z == '0))
    else $error("miss with nonzero payload");

  a_hit_beyond_min: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.hit && !$past(cfg_write)) |-> (res.distance >= min_distance))
    else $error("hit below minimum distance");

endmodule

`default_nettype wire

/* sim/ray_plane_intersect_tb.sv */
// ----------------------------------------------------------------------------
// ray_plane_intersect_tb
// Self-checking bench for the ray / plane intersection pipeline: a scoreboard
// predicts each result from the accepted ray and the current triangle, and
// checks results in order under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class intersect_scoreboard;
  logic [rpi_pkg::VERTEX_W-1:0] va, vb, vc;
  logic [rpi_pkg::DIST_W-1:0]   min_dist;
  rpi_pkg::result_t             pending[$];
  int                           mismatches;

  function new();
    va = '0; vb = '0; vc = '0; min_dist = rpi_pkg::MIN_DIST_RESET; mismatches = 0;
  endfunction

  function void set_reg(rpi_pkg::cfg_reg_t idx, logic [rpi_pkg::VERTEX_W-1:0] v);
    case (idx)
      rpi_pkg::REG_VERTEX_A: va = v;
      rpi_pkg::REG_VERTEX_B: vb = v;
      rpi_pkg::REG_VERTEX_C: vc = v;
      rpi_pkg::REG_MIN_DIST: min_dist = v[rpi_pkg::DIST_W-1:0];
    endcase
  endfunction

  function automatic logic signed [127:0] cx(logic [rpi_pkg::VERTEX_W-1:0] v, int k);
    logic signed [rpi_pkg::COORD_W-1:0] c;
    c = v[k*rpi_pkg::COORD_W +: rpi_pkg::COORD_W];
    return 128'(c);
  endfunction

  function void note_ray(rpi_pkg::ray_t r);
    logic signed [127:0] ab[3], ac[3], n[3], o[3], d[3];
    logic signed [127:0] num, den, p, prod;
    logic [127:0] q;
    logic sat;
    logic [rpi_pkg::DIST_W-1:0] t;
    rpi_pkg::result_t e;
    e = '0;
    for (int k = 0; k < 3; k++) begin
      ab[k] = cx(vb, k) - cx(va, k);
      ac[k] = cx(vc, k) - cx(va, k);
    end
    n[0] = ab[1]*ac[2] - ab[2]*ac[1];
    n[1] = ab[2]*ac[0] - ab[0]*ac[2];
    n[2] = ab[0]*ac[1] - ab[1]*ac[0];
    o[0] = 128'(r.origin_x); o[1] = 128'(r.origin_y); o[2] = 128'(r.origin_z);
    d[0] = 128'(r.dir_x); d[1] = 128'(r.dir_y); d[2] = 128'(r.dir_z);
    den = n[0]*d[0] + n[1]*d[1] + n[2]*d[2];
    num = n[0]*(cx(va,0)-o[0]) + n[1]*(cx(va,1)-o[1]) + n[2]*(cx(va,2)-o[2]);
    if (den != 0 && !(num != 0 && ((num < 0) != (den < 0)))) begin
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      q = (num <<< rpi_pkg::DIST_FRAC) / den;
      sat = q >= 128'h1_0000_0000;
      t = sat ? rpi_pkg::DIST_MAX : q[rpi_pkg::DIST_W-1:0];
      if (t >= min_dist) begin
        e.hit = 1'b1;
        e.distance = t;
        for (int k = 0; k < 3; k++) begin
          if (d[k] == 0) p = o[k];
          else if (sat) p = d[k] > 0 ? 128'sd40000 : -128'sd40000;
          else begin
            prod = d[k] * $signed({96'd0, t}) + 128'sd32768;
            p = o[k] + (prod >>> rpi_pkg::DIST_FRAC);
          end
          if (p > 32767) p = 32767;
          if (p < -32768) p = -32768;
          case (k)
            0: e.point_x = p[15:0];
            1: e.point_y = p[15:0];
            default: e.point_z = p[15:0];
          endcase
        end
      end
    end
    pending.push_back(e);
  endfunction

  function void check_result(rpi_pkg::result_t got);
    rpi_pkg::result_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    e = pending.pop_front();
    if (got.hit !== e.hit || got.distance !== e.distance || got.point_x !== e.point_x
        || got.point_y !== e.point_y || got.point_z !== e.point_z) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected hit %0d t %h p %h %h %h, got hit %0d t %h p %h %h %h",
                 e.hit, e.distance, e.point_x, e.point_y, e.point_z,
                 got.hit, got.distance, got.point_x, got.point_y, got.point_z);
    end
  endfunction
endclass

module ray_plane_intersect_tb;
  localparam int LATENCY = 38;
  localparam int WATCHDOG = 2000;

  logic clk, rst;
  logic ray_valid, ray_stall, res_valid, res_stall;
  rpi_pkg::ray_t ray;
  rpi_pkg::result_t res;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [rpi_pkg::VERTEX_W-1:0] cfg_data;

  intersect_scoreboard sb;
  bit idle_on;
  int quiet;

  ray_plane_intersect dut (
    .clk(clk), .rst(rst),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: stall bursts and checking
  initial begin
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) sb.check_result(res);
      if (idle_on && $urandom_range(0, 15) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) begin
          @(posedge clk);
        end
        res_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (ray_valid && !ray_stall) || (res_valid && !res_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("ray_plane_intersect verification failed");
      $finish;
    end
  end

  task automatic write_reg(rpi_pkg::cfg_reg_t idx, logic [rpi_pkg::VERTEX_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_ray(rpi_pkg::ray_t r);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      ray_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    ray_valid <= 1'b1;
    ray <= r;
    @(posedge clk);
    while (ray_stall) @(posedge clk);
    sb.note_ray(r);
  endtask

  task automatic set_triangle(logic [rpi_pkg::VERTEX_W-1:0] a,
                              logic [rpi_pkg::VERTEX_W-1:0] b,
                              logic [rpi_pkg::VERTEX_W-1:0] c);
    ray_valid <= 1'b0;
    drain();
    write_reg(rpi_pkg::REG_VERTEX_A, a);
    write_reg(rpi_pkg::REG_VERTEX_B, b);
    write_reg(rpi_pkg::REG_VERTEX_C, c);
  endtask

  function automatic rpi_pkg::ray_t aimed_ray(logic [rpi_pkg::VERTEX_W-1:0] a);
    rpi_pkg::ray_t r;
    r = {pick16(), pick16(), pick16(), pick16(), pick16(), pick16()};
    if ($urandom_range(0, 1)) begin
      // point the ray roughly from the origin towards vertex a
      r.dir_x = a[15:0] - r.origin_x;
      r.dir_y = a[31:16] - r.origin_y;
      r.dir_z = a[47:32] - r.origin_z;
      if ($urandom_range(0, 1)) begin
        r.dir_x = r.dir_x >>> 3; r.dir_y = r.dir_y >>> 3; r.dir_z = r.dir_z >>> 3;
      end
    end
    return r;
  endfunction

  initial begin
    logic [rpi_pkg::VERTEX_W-1:0] a, b, c;
    rpi_pkg::ray_t r;
    sb = new();
    idle_on = 1'b1;
    rst = 1'b1;
    ray_valid = 1'b0;
    ray = '0;
    cfg_write = 1'b0;
    cfg_index = rpi_pkg::REG_VERTEX_A;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // degenerate triangle straight after reset: every ray is parallel
    send_ray('0);
    send_ray({6{16'h7fff}});

    // plane z = 0 with normal along +z
    set_triangle({16'd0, 16'd0, 16'd0}, {16'd0, 16'd0, 16'h0100},
                 {16'd0, 16'h0100, 16'd0});
    send_ray({16'd0, 16'd0, 16'h0100, 16'd0, 16'd0, 16'hff00});   // hit at t 1
    send_ray({16'd0, 16'd0, 16'h0100, 16'd0, 16'd0, 16'h0100});   // plane behind
    send_ray({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0100});      // origin on plane
    send_ray({16'h0100, 16'd0, 16'h0100, 16'h0100, 16'd0, 16'd0}); // parallel
    send_ray({16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff}); // huge t
    send_ray({16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h0001}); // huge t
    send_ray({16'h1234, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    send_ray({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_ray({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000});
    ray_valid <= 1'b0;
    drain();
    write_reg(rpi_pkg::REG_MIN_DIST, '0);
    send_ray({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0100});      // origin on plane hits
    send_ray({16'd5, 16'd0, 16'hff00, 16'h0080, 16'd0, 16'h0300});
    ray_valid <= 1'b0;
    drain();
    write_reg(rpi_pkg::REG_MIN_DIST, 48'hffff_ffff);
    send_ray({16'd0, 16'd0, 16'h0100, 16'd0, 16'd0, 16'hff00});
    send_ray({16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff});
    set_triangle({48{1'b1}}, 48'h7fff_8000_7fff, 48'h8000_7fff_0000);
    write_reg(rpi_pkg::REG_MIN_DIST, 48'hffff_0000_0042); // upper bits ignored

    for (int i = 0; i < 500; i++) begin
      if (i % 60 == 0) begin
        a = {pick16(), pick16(), pick16()};
        b = $urandom_range(0, 7) == 0 ? a : {pick16(), pick16(), pick16()};
        c = {pick16(), pick16(), pick16()};
        set_triangle(a, b, c);
        case ($urandom_range(0, 3))
          0: write_reg(rpi_pkg::REG_MIN_DIST, '0);
          1: write_reg(rpi_pkg::REG_MIN_DIST, 48'($urandom));
          2: write_reg(rpi_pkg::REG_MIN_DIST, 48'hffff_ffff);
          default: write_reg(rpi_pkg::REG_MIN_DIST, 48'(rpi_pkg::MIN_DIST_RESET));
        endcase
      end
      if (i == 420) idle_on = 1'b0;
      r = aimed_ray(a);
      send_ray(r);
    end
    ray_valid <= 1'b0;
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("ray_plane_intersect verification clean");
    else
      $display("ray_plane_intersect verification failed");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/rpi_pkg.sv
rtl/core/rpi_normal.sv
rtl/core/rpi_front.sv
rtl/core/rpi_div.sv
rtl/core/rpi_back.sv
rtl/core/ray_plane_intersect.sv
sim/ray_plane_intersect_tb.sv
